>>> rtl/core/cmt_pkg.sv
// Shared types and constants for the code map table lookup block.
// Used by every module under rtl/core except cmt_ram; depends on nothing else.
package cmt_pkg;

	localparam int MAX_CELLS_DEF   = 64;
	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int CODE_W          = 16;
	localparam int SUM_W           = CODE_W + 1;
	localparam int CFG_IDX_W       = 2;
	localparam logic [CODE_W-1:0] NO_MAP_RESET = 16'hFFFD;

	typedef enum logic [1:0] {
		OP_WRITE_CELL = 2'd0,
		OP_WRITE_WORD = 2'd1,
		OP_LOOKUP     = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		FMT_OFFSET = 2'd0,
		FMT_TABLE  = 2'd1,
		FMT_SINGLE = 2'd2,
		FMT_UNUSED = 2'd3
	} fmt_t;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_MAP     = 2'd1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CODE_W-1:0] first;
		logic [CODE_W-1:0] last;
		logic [CODE_W-1:0] target;
	} cell_t;

	typedef struct packed {
		logic              hit;
		logic              use_table;
		logic [CODE_W-1:0] value;
		logic [SUM_W-1:0]  table_sum;
	} cmp_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOD,
		ST_TRD,
		ST_TDATA,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/code_map_table_lookup.sv
// Top level of the code map table lookup: sequencer, registers and memories.
// Depends on cmt_pkg, cmt_ram, cmt_cell_cmp and cmt_rem_step.
//
// Channel  Direction  Handshake             Beat carries
// in       input      in_valid / in_ready   operation and load or lookup fields
// out      output     out_valid / out_ready mapped, result_code
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A lookup visits 0 .. min(cell_count, MAX_CELLS) cells, one per cycle through the
// cell RAM read port. When a table cell hits, the remainder by the table depth runs
// through estimate, back-subtract and correct, and the table RAM is then read.
// in_ready is low while a lookup runs and while its result waits for the output
// register. Reset clears the control state, cell count and out_valid and loads
// NO_MAP_RESET; datapath registers and cell and table memories are not cleared.
module code_map_table_lookup #(
	parameter int MAX_CELLS   = cmt_pkg::MAX_CELLS_DEF,
	parameter int TABLE_DEPTH = cmt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [5:0]                    cell_index,
	input  logic [1:0]                    cell_format,
	input  logic [15:0]                   source_first,
	input  logic [15:0]                   source_last,
	input  logic [15:0]                   target_value,
	input  logic [11:0]                   word_index,
	input  logic [15:0]                   word_value,
	input  logic [15:0]                   source_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          mapped,
	output logic [15:0]                   result_code,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import cmt_pkg::*;

	localparam int CAW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int KW    = $clog2(MAX_CELLS + 1);
	localparam int TAW   = $clog2(TABLE_DEPTH);
	// The remainder runs in three steps: estimate, back-subtract, correct.
	localparam int S_MAX = 2;
	localparam int SW    = 2;

	state_t state_q, state_d;

	logic [6:0]        cell_count_q;
	logic [CODE_W-1:0] no_map_q;
	logic [CODE_W-1:0] code_q;
	logic [KW-1:0]     n_q;
	logic [KW-1:0]     k_q;
	logic [KW-1:0]     k_inc;
	logic [KW-1:0]     n_lim;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [SUM_W-1:0]  quo_est;
	logic [SUM_W-1:0]  rem_sub;
	logic [SUM_W-1:0]  rem_fix;
	logic [SW-1:0]     s_q;
	logic              hit_q;
	logic [CODE_W-1:0] res_q;
	logic              out_valid_q;
	logic              mapped_q;
	logic [CODE_W-1:0] result_q;

	logic              in_fire;
	logic              is_lookup;
	logic              last_cell;
	logic              cell_we;
	logic              word_we;
	logic [CAW-1:0]    cell_waddr;
	logic [CAW-1:0]    cell_raddr;
	logic [TAW-1:0]    word_waddr;
	logic [31:0]       cell_idx_wide;
	logic [31:0]       word_idx_wide;
	logic              out_free;
	cell_t             cell_wdata;
	cell_t             cell_rdata;
	logic [CODE_W-1:0] word_rdata;
	cmp_res_t          cmp;

	assign in_fire   = in_valid && in_ready;
	assign is_lookup = (op_t'(operation) == OP_LOOKUP);
	assign k_inc     = k_q + KW'(1);
	assign last_cell = (k_inc == n_q);
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign n_lim = (32'(cell_count_q) > 32'(MAX_CELLS)) ? KW'(MAX_CELLS)
		: KW'(cell_count_q);

	// Writes beyond the store depth are dropped.
	assign cell_idx_wide = 32'(cell_index);
	assign word_idx_wide = 32'(word_index);
	assign cell_waddr    = cell_idx_wide[CAW-1:0];
	assign word_waddr    = word_idx_wide[TAW-1:0];
	assign cell_we = in_fire && (op_t'(operation) == OP_WRITE_CELL)
		&& (cell_idx_wide < 32'(MAX_CELLS));
	assign word_we = in_fire && (op_t'(operation) == OP_WRITE_WORD)
		&& (word_idx_wide < 32'(TABLE_DEPTH));
	assign cell_wdata = '{kind: cell_format, first: source_first,
		last: source_last, target: target_value};

	// The read of the next cell is issued while the current one is compared.
	assign cell_raddr = (state_q == ST_IDLE) ? CAW'(0) : k_inc[CAW-1:0];

	cmt_ram #(.WIDTH($bits(cell_t)), .DEPTH(MAX_CELLS), .AW(CAW)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	cmt_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH), .AW(TAW)) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (word_value),
		.raddr (rem_q[TAW-1:0]),
		.rdata (word_rdata)
	);

	cmt_cell_cmp u_cmp (
		.code  (code_q),
		.entry (cell_rdata),
		.res   (cmp)
	);

	cmt_rem_step #(.DIVISOR(TABLE_DEPTH)) u_rem (
		.rem     (rem_q),
		.quo     (quo_q),
		.quo_est (quo_est),
		.rem_sub (rem_sub),
		.rem_fix (rem_fix)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && is_lookup) begin
					state_d = (n_lim == KW'(0)) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp.hit) begin
					state_d = cmp.use_table ? ST_MOD : ST_DONE;
				end else if (last_cell) begin
					state_d = ST_DONE;
				end
			end
			ST_MOD: begin
				if (s_q == SW'(0)) begin
					state_d = ST_TRD;
				end
			end
			ST_TRD:   state_d = ST_TDATA;
			ST_TDATA: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cell_count_q <= '0;
			no_map_q     <= NO_MAP_RESET;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CELL_COUNT) begin
					cell_count_q <= cfg_data[6:0];
				end else if (cfg_index == CFG_NO_MAP) begin
					no_map_q <= cfg_data;
				end
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: hit_q <= 1'b0;
				ST_SCAN: begin
					if (cmp.hit && !cmp.use_table) begin
						hit_q <= 1'b1;
					end
				end
				ST_TDATA: hit_q <= 1'b1;
				default: hit_q <= hit_q;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				code_q <= source_code;
				n_q    <= n_lim;
				k_q    <= '0;
			end
			ST_SCAN: begin
				k_q   <= k_inc;
				res_q <= cmp.value;
				rem_q <= cmp.table_sum;
				s_q   <= SW'(S_MAX);
			end
			ST_MOD: begin
				case (s_q)
					SW'(S_MAX): quo_q <= quo_est;
					SW'(1):     rem_q <= rem_sub;
					default:    rem_q <= rem_fix;
				endcase
				s_q <= s_q - SW'(1);
			end
			ST_TDATA: res_q <= word_rdata;
			ST_DONE: begin
				if (out_free) begin
					result_q <= hit_q ? res_q : no_map_q;
					mapped_q <= hit_q && (res_q != no_map_q);
				end
			end
			default: rem_q <= rem_q;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign mapped      = mapped_q;
	assign result_code = result_q;

endmodule

>>> rtl/core/cmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module cmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/cmt_cell_cmp.sv
// Cell match unit: tests one mapping cell against the code and forms its translation.
// Depends on cmt_pkg.
module cmt_cell_cmp (
	input  logic [cmt_pkg::CODE_W-1:0] code,
	input  cmt_pkg::cell_t             entry,
	output cmt_pkg::cmp_res_t          res
);
	import cmt_pkg::*;

	logic [CODE_W-1:0] delta;
	logic              in_range;

	assign delta    = code - entry.first;
	assign in_range = (code >= entry.first) && (code <= entry.last);

	always_comb begin
		res.use_table = 1'b0;
		res.value     = CODE_W'(entry.target + delta);
		res.table_sum = SUM_W'({1'b0, delta}) + SUM_W'({1'b0, entry.target});
		case (fmt_t'(entry.kind))
			FMT_OFFSET: res.hit = in_range;
			FMT_TABLE: begin
				res.hit       = in_range;
				res.use_table = 1'b1;
			end
			FMT_SINGLE: begin
				res.hit   = (code == entry.first);
				res.value = entry.target;
			end
			default: res.hit = 1'b0;
		endcase
	end

endmodule

>>> rtl/core/cmt_rem_step.sv
// Remainder by the table depth: reciprocal estimate, back-subtract and one correction.
// Depends on cmt_pkg.
module cmt_rem_step #(
	parameter int DIVISOR = cmt_pkg::TABLE_DEPTH_DEF
) (
	input  logic [cmt_pkg::SUM_W-1:0] rem,
	input  logic [cmt_pkg::SUM_W-1:0] quo,
	output logic [cmt_pkg::SUM_W-1:0] quo_est,
	output logic [cmt_pkg::SUM_W-1:0] rem_sub,
	output logic [cmt_pkg::SUM_W-1:0] rem_fix
);
	import cmt_pkg::*;

	localparam int PW    = 2 * SUM_W;
	localparam int RECIP = (1 << SUM_W) / DIVISOR;

	logic [PW-1:0] est_prod;
	logic [PW-1:0] back_prod;

	// The estimate never exceeds the true quotient and falls short by at most one,
	// so the back-subtracted value is below twice the divisor.
	assign est_prod  = PW'(rem) * PW'(RECIP);
	assign quo_est   = est_prod[PW-1:SUM_W];
	assign back_prod = PW'(quo) * PW'(DIVISOR);
	assign rem_sub   = rem - back_prod[SUM_W-1:0];
	assign rem_fix   = (rem >= SUM_W'(DIVISOR)) ? (rem - SUM_W'(DIVISOR)) : rem;

endmodule
